// ===== rtl/mf_pkg.sv =====
// shared constants and types of the 3x3 median filter
package mf_pkg;

    localparam int MF_MAX_WIDTH    = 2048;
    localparam int MF_PIXEL_BITS   = 8;
    localparam int MF_TAPS         = 9;
    localparam int MF_CFG_BITS     = 12;
    localparam int MF_ROW_BITS     = 12;
    localparam int MF_HEIGHT_LIMIT = 2048;
    localparam int MF_WIDTH_RESET  = 640;
    localparam int MF_HEIGHT_RESET = 480;
    localparam int MF_ADDR_BITS    = 3;
    localparam int MF_APB_BITS     = 32;
    localparam int MF_WQ_LOG2      = 2;
    localparam int MF_OQ_LOG2      = 1;

    // register index, taken from paddr[2]
    typedef enum logic {
        MF_REG_WIDTH  = 1'b0,
        MF_REG_HEIGHT = 1'b1
    } t_mf_reg;

    // row and frame markers that travel with each result
    typedef struct packed {
        logic eor;
        logic eof;
    } t_mf_flags;

endpackage

// ===== rtl/mf_fifo.sv =====
// small register queue with push/full and pop/empty sides
module mf_fifo #(
    parameter int WIDTH      = 8,
    parameter int DEPTH_LOG2 = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int DEPTH = 1 << DEPTH_LOG2;

    logic [WIDTH-1:0]      r_mem [DEPTH];
    logic [DEPTH_LOG2-1:0] r_wr;
    logic [DEPTH_LOG2-1:0] r_rd;
    logic [DEPTH_LOG2:0]   r_cnt;
    logic                  wr_en;
    logic                  rd_en;

    assign o_full  = (r_cnt == (DEPTH_LOG2 + 1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= r_wr + 1'b1;
            end
            if (rd_en) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ===== rtl/mf_front.sv =====
// front end: position counters, line stores, window register, tap masking
module mf_front
    import mf_pkg::*;
#(
    parameter int MAX_WIDTH  = MF_MAX_WIDTH,
    parameter int PIXEL_BITS = MF_PIXEL_BITS,
    localparam int WB        = $clog2(MAX_WIDTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_clear,
    input  logic [WB-1:0]                 i_width,
    input  logic [MF_ROW_BITS-1:0]        i_height,
    input  logic                          i_push,
    input  logic                          i_func,
    input  logic [PIXEL_BITS-1:0]         i_pixel,
    output logic                          o_full,
    output logic                          o_win_push,
    output logic [MF_TAPS*PIXEL_BITS-1:0] o_win,
    output t_mf_flags                     o_flags,
    input  logic                          i_win_full
);

    localparam int COL_BITS = $clog2(MAX_WIDTH);

    typedef logic [PIXEL_BITS-1:0] t_pix;

    typedef struct packed {
        logic      up_ok;
        logic      lo_ok;
        logic      have;
        logic      sel_pre;
        logic      left_ok;
        logic      top_ok;
        logic      bot_ok;
        t_mf_flags flags;
    } t_ctl;

    logic [COL_BITS-1:0]    r_col;
    logic [MF_ROW_BITS-1:0] r_row;
    logic                   r_b_valid;
    logic [COL_BITS-1:0]    r_b_addr;
    t_pix                   r_b_px;
    t_ctl                   r_b_ctl;
    t_pix                   r_rd_up;
    t_pix                   r_rd_lo;
    logic                   r_fwd;
    t_pix                   r_fwd_up;
    t_pix                   r_fwd_lo;
    t_pix                   r_win [MF_TAPS];
    t_pix                   r_up_mem [MAX_WIDTH];
    t_pix                   r_lo_mem [MAX_WIDTH];

    logic [COL_BITS-1:0]    c_eff;
    logic [WB-1:0]          c_inc;
    logic [COL_BITS-1:0]    n_col;
    logic [MF_ROW_BITS-1:0] n_row;
    t_ctl                   n_ctl;
    t_pix                   px;
    logic                   accept;
    logic                   b_fire;
    logic                   row_past;
    logic                   col_zero;
    logic                   pre_have;
    logic                   post_have;
    t_pix                   up_raw;
    t_pix                   lo_raw;
    t_pix                   new_col [3];
    t_pix                   n_win [MF_TAPS];
    logic                   row_ok;

    assign o_full = r_b_valid && i_win_full;
    assign accept = i_push && !o_full;
    assign b_fire = r_b_valid && !i_win_full;
    assign px     = i_func ? '0 : i_pixel;

    // position of the incoming item and what it produces
    always_comb begin
        c_eff     = (WB'(r_col) >= i_width) ? '0 : r_col;
        row_past  = (r_row > i_height);
        col_zero  = (c_eff == '0);
        pre_have  = col_zero && (r_row >= MF_ROW_BITS'(2));
        post_have = !col_zero && (r_row != '0) && !row_past;

        n_ctl.up_ok     = (r_row >= MF_ROW_BITS'(2));
        n_ctl.lo_ok     = (r_row != '0);
        n_ctl.have      = pre_have || post_have;
        n_ctl.sel_pre   = col_zero;
        n_ctl.left_ok   = col_zero ? (i_width >= WB'(2)) : (WB'(c_eff) >= WB'(2));
        n_ctl.top_ok    = col_zero ? (r_row >= MF_ROW_BITS'(3)) : (r_row >= MF_ROW_BITS'(2));
        n_ctl.bot_ok    = col_zero ? !row_past : (r_row < i_height);
        n_ctl.flags.eor = pre_have;
        n_ctl.flags.eof = pre_have && row_past;

        c_inc = WB'(c_eff) + WB'(1);
        if (row_past) begin
            n_col = '0;
            n_row = '0;
        end else if (c_inc >= i_width) begin
            n_col = '0;
            n_row = r_row + 1'b1;
        end else begin
            n_col = COL_BITS'(c_inc);
            n_row = r_row;
        end
    end

    // stage b: effective store reads, window shift and masked taps
    always_comb begin
        up_raw     = r_fwd ? r_fwd_up : r_rd_up;
        lo_raw     = r_fwd ? r_fwd_lo : r_rd_lo;
        new_col[0] = r_b_ctl.up_ok ? up_raw : '0;
        new_col[1] = r_b_ctl.lo_ok ? lo_raw : '0;
        new_col[2] = r_b_px;
        o_win      = '0;
        for (int i = 0; i < 3; i++) begin
            n_win[3*i]     = r_win[3*i+1];
            n_win[3*i+1]   = r_win[3*i+2];
            n_win[3*i+2]   = new_col[i];
            row_ok         = (i == 0) ? r_b_ctl.top_ok : ((i == 2) ? r_b_ctl.bot_ok : 1'b1);
            // end-of-row results see the old window, whose centre and right
            // equal the shifted window's left and centre
            o_win[(3*i)*PIXEL_BITS +: PIXEL_BITS] =
                (row_ok && r_b_ctl.left_ok) ? n_win[3*i] : '0;
            o_win[(3*i+1)*PIXEL_BITS +: PIXEL_BITS] = row_ok ? n_win[3*i+1] : '0;
            o_win[(3*i+2)*PIXEL_BITS +: PIXEL_BITS] =
                (row_ok && !r_b_ctl.sel_pre) ? n_win[3*i+2] : '0;
        end
    end

    assign o_win_push = b_fire && r_b_ctl.have;
    assign o_flags    = r_b_ctl.flags;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_b_valid <= 1'b0;
            r_fwd     <= 1'b0;
            for (int k = 0; k < MF_TAPS; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            if (i_cfg_clear) begin
                r_col <= '0;
                r_row <= '0;
            end else if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (accept) begin
                r_b_valid <= 1'b1;
                r_fwd     <= b_fire && (r_b_addr == c_eff);
            end else if (b_fire) begin
                r_b_valid <= 1'b0;
            end
            if (b_fire) begin
                for (int k = 0; k < MF_TAPS; k++) begin
                    r_win[k] <= n_win[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_addr <= c_eff;
            r_b_px   <= px;
            r_b_ctl  <= n_ctl;
            r_fwd_up <= lo_raw;
            r_fwd_lo <= r_b_px;
        end
    end

    // line stores: write from stage b, read for the accepted item
    always_ff @(posedge i_clk) begin
        if (b_fire) begin
            r_up_mem[r_b_addr] <= lo_raw;
            r_lo_mem[r_b_addr] <= r_b_px;
        end
        if (accept) begin
            r_rd_up <= r_up_mem[c_eff];
            r_rd_lo <= r_lo_mem[c_eff];
        end
    end

    a_col_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WB'(r_col) < i_width)
        else $error("column count past row width");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (MF_ROW_BITS + 1)'(r_row) <= (MF_ROW_BITS + 1)'(i_height) + (MF_ROW_BITS + 1)'(1))
        else $error("row count past flush row");

    a_b_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && i_win_full |=> r_b_valid)
        else $error("stage b dropped an item while the queue was full");

endmodule

// ===== rtl/mf_median.sv =====
// back end: three-stage median-of-nine compare-exchange pipeline
module mf_median
    import mf_pkg::*;
#(
    parameter int PIXEL_BITS = MF_PIXEL_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [MF_TAPS*PIXEL_BITS-1:0] i_win,
    input  t_mf_flags                     i_flags,
    output logic                          o_ready,
    output logic                          o_valid,
    output logic [PIXEL_BITS-1:0]         o_median,
    output t_mf_flags                     o_flags,
    input  logic                          i_ready
);

    typedef logic [PIXEL_BITS-1:0]             t_pix;
    typedef logic [MF_TAPS-1:0][PIXEL_BITS-1:0] t_vec;
    typedef logic [3:0]                        t_idx;

    function automatic t_vec cx(t_vec v, t_idx a, t_idx b);
        t_pix va;
        t_pix vb;
        va = v[a];
        vb = v[b];
        if (va > vb) begin
            v[a] = vb;
            v[b] = va;
        end
        return v;
    endfunction

    logic      r_v1, r_v2, r_v3;
    t_vec      r_p1, r_p2;
    t_pix      r_m3;
    t_mf_flags r_f1, r_f2, r_f3;
    t_vec      s1, s2, s3;
    logic      adv1, adv2, adv3;

    assign adv3    = !r_v3 || i_ready;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    // sort the three rows
    always_comb begin
        s1 = t_vec'(i_win);
        s1 = cx(s1, 4'd1, 4'd2);
        s1 = cx(s1, 4'd4, 4'd5);
        s1 = cx(s1, 4'd7, 4'd8);
        s1 = cx(s1, 4'd0, 4'd1);
        s1 = cx(s1, 4'd3, 4'd4);
        s1 = cx(s1, 4'd6, 4'd7);
        s1 = cx(s1, 4'd1, 4'd2);
        s1 = cx(s1, 4'd4, 4'd5);
        s1 = cx(s1, 4'd7, 4'd8);
    end

    // cross-row merges
    always_comb begin
        s2 = r_p1;
        s2 = cx(s2, 4'd0, 4'd3);
        s2 = cx(s2, 4'd5, 4'd8);
        s2 = cx(s2, 4'd4, 4'd7);
        s2 = cx(s2, 4'd3, 4'd6);
        s2 = cx(s2, 4'd1, 4'd4);
        s2 = cx(s2, 4'd2, 4'd5);
    end

    // final narrowing onto the middle element
    always_comb begin
        s3 = r_p2;
        s3 = cx(s3, 4'd4, 4'd7);
        s3 = cx(s3, 4'd2, 4'd4);
        s3 = cx(s3, 4'd4, 4'd6);
        s3 = cx(s3, 4'd2, 4'd4);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_p1 <= s1;
            r_f1 <= i_flags;
        end
        if (adv2) begin
            r_p2 <= s2;
            r_f2 <= r_f1;
        end
        if (adv3) begin
            r_m3 <= s3[4];
            r_f3 <= r_f2;
        end
    end

    assign o_valid  = r_v3;
    assign o_median = r_m3;
    assign o_flags  = r_f3;

endmodule

// ===== rtl/median_filter_3x3.sv =====
// top level of the streaming 3x3 median filter with its register port
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  pixel in  | push / full          | i_func, i_pixel
//  result    | pop / empty          | o_median, o_end_of_row, o_end_of_frame
//  registers | psel/penable/pready  | paddr, pwrite, pwdata, prdata
//
//  one pixel beat is taken per cycle while full is low; full rises only when
//  the window queue and the front's output stage are both backed up
//  a result reaches the result ports once the beat that completes its window
//  has passed one front stage, the window queue, three median stages and
//  the result queue
//  i_rst_n is synchronous and active low; it clears counters, window and queues
//  line store contents are not cleared; only rows already written in the
//  current frame are ever read, the rest is masked to zero
//  a register write restarts the frame position at row zero, column zero
module median_filter_3x3
    import mf_pkg::*;
#(
    parameter int MAX_WIDTH  = MF_MAX_WIDTH,
    parameter int PIXEL_BITS = MF_PIXEL_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [MF_ADDR_BITS-1:0] paddr,
    input  logic [MF_APB_BITS-1:0]  pwdata,
    output logic [MF_APB_BITS-1:0]  prdata,
    output logic                    pready,
    input  logic                    push,
    output logic                    full,
    input  logic                    i_func,
    input  logic [PIXEL_BITS-1:0]   i_pixel,
    output logic                    empty,
    input  logic                    pop,
    output logic [PIXEL_BITS-1:0]   o_median,
    output logic                    o_end_of_row,
    output logic                    o_end_of_frame
);

    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int CW    = (MF_CFG_BITS > WB) ? MF_CFG_BITS : WB;
    localparam int WIN_W = MF_TAPS * PIXEL_BITS;
    localparam int FL_W  = $bits(t_mf_flags);

    // configuration registers
    logic [MF_CFG_BITS-1:0] r_width;
    logic [MF_CFG_BITS-1:0] r_height;
    logic                   cfg_wr;
    logic [CW-1:0]          raw_w;
    logic [WB-1:0]          w_used;
    logic [MF_ROW_BITS-1:0] h_used;

    // front to window queue
    logic                   f_push;
    logic [WIN_W-1:0]       f_win;
    t_mf_flags              f_flags;
    logic                   wq_full;
    logic                   wq_empty;
    logic [WIN_W-1:0]       wq_win;
    t_mf_flags              wq_flags;

    // median unit to result queue
    logic                   med_ready;
    logic                   med_valid;
    logic [PIXEL_BITS-1:0]  med_value;
    t_mf_flags              med_flags;
    logic                   oq_full;
    t_mf_flags              oq_flags;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= MF_CFG_BITS'(MF_WIDTH_RESET);
            r_height <= MF_CFG_BITS'(MF_HEIGHT_RESET);
        end else if (cfg_wr) begin
            case (t_mf_reg'(paddr[2]))
                MF_REG_WIDTH:  r_width  <= pwdata[MF_CFG_BITS-1:0];
                MF_REG_HEIGHT: r_height <= pwdata[MF_CFG_BITS-1:0];
                default:       r_width  <= r_width;
            endcase
        end
    end

    // register read back
    always_comb begin
        case (t_mf_reg'(paddr[2]))
            MF_REG_WIDTH:  prdata = {{(MF_APB_BITS - MF_CFG_BITS){1'b0}}, r_width};
            MF_REG_HEIGHT: prdata = {{(MF_APB_BITS - MF_CFG_BITS){1'b0}}, r_height};
            default:       prdata = '0;
        endcase
    end

    // zero acts as one, values above the limit act as the limit
    always_comb begin
        raw_w = CW'(r_width);
        if (raw_w == '0) begin
            w_used = WB'(1);
        end else if (raw_w > CW'(MAX_WIDTH)) begin
            w_used = WB'(MAX_WIDTH);
        end else begin
            w_used = WB'(raw_w);
        end
        if (r_height == '0) begin
            h_used = MF_ROW_BITS'(1);
        end else if (r_height > MF_CFG_BITS'(MF_HEIGHT_LIMIT)) begin
            h_used = MF_ROW_BITS'(MF_HEIGHT_LIMIT);
        end else begin
            h_used = MF_ROW_BITS'(r_height);
        end
    end

    mf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_clear (cfg_wr),
        .i_width     (w_used),
        .i_height    (h_used),
        .i_push      (push),
        .i_func      (i_func),
        .i_pixel     (i_pixel),
        .o_full      (full),
        .o_win_push  (f_push),
        .o_win       (f_win),
        .o_flags     (f_flags),
        .i_win_full  (wq_full)
    );

    // masked windows waiting for the median unit
    mf_fifo #(
        .WIDTH      (FL_W + WIN_W),
        .DEPTH_LOG2 (MF_WQ_LOG2)
    ) u_win_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_data  ({f_flags, f_win}),
        .o_full  (wq_full),
        .i_pop   (med_ready),
        .o_data  ({wq_flags, wq_win}),
        .o_empty (wq_empty)
    );

    mf_median #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_median (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!wq_empty),
        .i_win    (wq_win),
        .i_flags  (wq_flags),
        .o_ready  (med_ready),
        .o_valid  (med_valid),
        .o_median (med_value),
        .o_flags  (med_flags),
        .i_ready  (!oq_full)
    );

    // finished results; the head beat sits on the result ports
    mf_fifo #(
        .WIDTH      (FL_W + PIXEL_BITS),
        .DEPTH_LOG2 (MF_OQ_LOG2)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (med_valid),
        .i_data  ({med_flags, med_value}),
        .o_full  (oq_full),
        .i_pop   (pop),
        .o_data  ({oq_flags, o_median}),
        .o_empty (empty)
    );

    assign o_end_of_row   = oq_flags.eor;
    assign o_end_of_frame = oq_flags.eof;

    a_win_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        f_push |-> !wq_full)
        else $error("window beat pushed into a full queue");

    a_eof_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_end_of_frame |-> o_end_of_row)
        else $error("frame end marked on a beat that does not end a row");

    a_median_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        med_valid && oq_full |=> med_valid)
        else $error("median result lost while result queue was full");

endmodule

// ===== dv/mf_median_check.sv =====
`timescale 1ns / 1ps
// checker of the 3x3 median filter: predicts filtered pixels and compares result beats
module mf_median_check
    import mf_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [MF_ADDR_BITS-1:0]  paddr,
    input  logic [MF_APB_BITS-1:0]   pwdata,
    input  logic [MF_APB_BITS-1:0]   prdata,
    input  logic                     pready,
    input  logic                     push,
    input  logic                     full,
    input  logic                     i_func,
    input  logic [MF_PIXEL_BITS-1:0] i_pixel,
    input  logic                     empty,
    input  logic                     pop,
    input  logic [MF_PIXEL_BITS-1:0] o_median,
    input  logic                     o_end_of_row,
    input  logic                     o_end_of_frame,
    output int                       o_mismatches,
    output int                       o_outstanding,
    output int                       o_compared
);

    localparam int MAX_SHOWN = 60;

    typedef logic [MF_PIXEL_BITS-1:0] t_px;

    typedef struct packed {
        t_px  median;
        logic eor;
        logic eof;
    } t_filtered_px;

    logic [MF_CFG_BITS-1:0] width_reg;
    logic [MF_CFG_BITS-1:0] height_reg;
    t_px                    upper_row [MF_MAX_WIDTH];
    t_px                    lower_row [MF_MAX_WIDTH];
    t_px                    win [MF_TAPS];
    int unsigned            col_pos;
    int unsigned            row_pos;
    t_filtered_px           filtered_due [$];
    int                     mismatches = 0;
    int                     compared = 0;

    assign o_mismatches = mismatches;
    assign o_compared   = compared;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            $display("%0t ns: beat %0d, %s: got %0d, want %0d",
                     $time, compared, what, got, want);
        end
    endtask

    // median of the nine window taps; a negative column or a masked border gives zero
    function automatic t_px window_median(input int lc, input int cc, input int rc,
                                          input bit left_ok, input bit top_ok,
                                          input bit bot_ok);
        t_px v [MF_TAPS];
        t_px key;
        int  cols [3];
        int  i;
        int  j;
        int  k;
        int  row;
        bit  ok;
        cols[0] = lc;
        cols[1] = cc;
        cols[2] = rc;
        for (row = 0; row < 3; row++) begin
            for (k = 0; k < 3; k++) begin
                ok = ((row == 0) ? top_ok : (row == 2) ? bot_ok : 1'b1)
                     && cols[k] >= 0 && (k != 0 || left_ok);
                v[row * 3 + k] = ok ? win[row * 3 + cols[k]] : '0;
            end
        end
        for (i = 1; i < MF_TAPS; i++) begin
            key = v[i];
            j = i - 1;
            while (j >= 0 && v[j] > key) begin
                v[j + 1] = v[j];
                j--;
            end
            v[j + 1] = key;
        end
        return v[MF_TAPS / 2];
    endfunction

    task automatic advance_window(input logic func, input t_px pix);
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        int unsigned  r;
        t_px          px;
        t_px          up;
        t_px          lo;
        t_filtered_px res;
        int           i;
        w = (width_reg == 0) ? 1 : (width_reg > MF_MAX_WIDTH) ? MF_MAX_WIDTH : width_reg;
        h = (height_reg == 0) ? 1 : (height_reg > MF_HEIGHT_LIMIT) ? MF_HEIGHT_LIMIT
                                                                   : height_reg;
        c = col_pos;
        r = row_pos;
        px = func ? '0 : pix;
        if (c >= w) begin
            c = 0;
        end
        // column zero closes the last centre of row r-2 from the window before the shift
        if (c == 0 && r >= 2) begin
            res.median = window_median(1, 2, -1, w >= 2, r >= 3, r - 1 < h);
            res.eor    = 1'b1;
            res.eof    = (r == h + 1);
            filtered_due.push_back(res);
        end
        up = (r >= 2) ? upper_row[c] : '0;
        lo = (r >= 1) ? lower_row[c] : '0;
        for (i = 0; i < 3; i++) begin
            win[i * 3]     = win[i * 3 + 1];
            win[i * 3 + 1] = win[i * 3 + 2];
        end
        win[2] = up;
        win[5] = lo;
        win[8] = px;
        upper_row[c] = lower_row[c];
        lower_row[c] = px;
        if (c >= 1 && r >= 1 && r <= h) begin
            res.median = window_median(0, 1, 2, c >= 2, r >= 2, r < h);
            res.eor    = 1'b0;
            res.eof    = 1'b0;
            filtered_due.push_back(res);
        end
        if (r >= h + 1) begin
            col_pos = 0;
            row_pos = 0;
        end else begin
            c++;
            if (c >= w) begin
                c = 0;
                r++;
            end
            col_pos = c;
            row_pos = r;
        end
    endtask

    always @(posedge i_clk) begin
        t_filtered_px due;
        if (!i_rst_n) begin
            width_reg  = MF_CFG_BITS'(MF_WIDTH_RESET);
            height_reg = MF_CFG_BITS'(MF_HEIGHT_RESET);
            foreach (win[k]) win[k] = '0;
            col_pos = 0;
            row_pos = 0;
            filtered_due.delete();
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (t_mf_reg'(paddr[2]) == MF_REG_WIDTH) begin
                        width_reg = pwdata[MF_CFG_BITS-1:0];
                    end else begin
                        height_reg = pwdata[MF_CFG_BITS-1:0];
                    end
                    col_pos = 0;
                    row_pos = 0;
                end else if (t_mf_reg'(paddr[2]) == MF_REG_WIDTH) begin
                    if (prdata !== MF_APB_BITS'(width_reg)) begin
                        report_mismatch("width register read", prdata,
                                        MF_APB_BITS'(width_reg));
                    end
                end else if (prdata !== MF_APB_BITS'(height_reg)) begin
                    report_mismatch("height register read", prdata,
                                    MF_APB_BITS'(height_reg));
                end
            end
            if (push && !full) begin
                advance_window(i_func, i_pixel);
            end
            if (pop && !empty) begin
                if (filtered_due.size() == 0) begin
                    report_mismatch("result beat with none due", 32'(o_median), 32'(0));
                end else begin
                    due = filtered_due.pop_front();
                    if (o_median !== due.median) begin
                        report_mismatch("median", 32'(o_median), 32'(due.median));
                    end
                    if (o_end_of_row !== due.eor) begin
                        report_mismatch("end_of_row", 32'(o_end_of_row), 32'(due.eor));
                    end
                    if (o_end_of_frame !== due.eof) begin
                        report_mismatch("end_of_frame", 32'(o_end_of_frame),
                                        32'(due.eof));
                    end
                    compared++;
                end
            end
        end
        o_outstanding = filtered_due.size();
    end

endmodule

// ===== dv/median_filter_3x3_test.sv =====
`timescale 1ns / 1ps
// testbench top of the 3x3 median filter: clock, reset, pixel and register stimulus, verdict
module median_filter_3x3_test;
    import mf_pkg::*;

    localparam int CLK_HALF_NS   = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_BEATS  = 500;
    // margin after the last due result before register writes
    localparam int SETTLE_CYCLES = 12;
    localparam int END_CYCLES    = 20;
    localparam int STALL_CYCLES  = 400;
    localparam int RUN_LIMIT_NS  = 3_000_000;

    // flavors of pixel content; flat and two-level content make ties in the sort
    typedef enum int {
        PX_RANDOM,
        PX_EXTREME,
        PX_NARROW,
        PX_FLAT
    } t_px_style;

    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [MF_ADDR_BITS-1:0]  paddr   = '0;
    logic [MF_APB_BITS-1:0]   pwdata  = '0;
    logic [MF_APB_BITS-1:0]   prdata;
    logic                     pready;
    logic                     push    = 1'b0;
    logic                     full;
    logic                     i_func  = 1'b0;
    logic [MF_PIXEL_BITS-1:0] i_pixel = '0;
    logic                     empty;
    logic                     pop     = 1'b0;
    logic [MF_PIXEL_BITS-1:0] o_median;
    logic                     o_end_of_row;
    logic                     o_end_of_frame;

    int mismatches;
    int results_due;
    int results_checked;

    // idle mix: 0 sender light / receiver heavy, 1 the reverse, 2 no idling
    int phase       = 0;
    int holds_asked = 0;
    int holds_done  = 0;
    int beats_sent  = 0;
    int frames_done = 0;
    int cur_w_set   = MF_WIDTH_RESET;
    int cur_h_set   = MF_HEIGHT_RESET;
    bit frame_cut   = 1'b0;

    median_filter_3x3 uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full), .i_func(i_func), .i_pixel(i_pixel),
        .empty(empty), .pop(pop), .o_median(o_median),
        .o_end_of_row(o_end_of_row), .o_end_of_frame(o_end_of_frame)
    );

    mf_median_check checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .push(push), .full(full), .i_func(i_func), .i_pixel(i_pixel),
        .empty(empty), .pop(pop), .o_median(o_median),
        .o_end_of_row(o_end_of_row), .o_end_of_frame(o_end_of_frame),
        .o_mismatches(mismatches), .o_outstanding(results_due),
        .o_compared(results_checked)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    function automatic int tx_idle_pct();
        case (phase)
            0:       return 22;
            1:       return 74;
            default: return 0;
        endcase
    endfunction

    function automatic int rx_idle_pct();
        case (phase)
            0:       return 74;
            1:       return 22;
            default: return 0;
        endcase
    endfunction

    function automatic logic [MF_PIXEL_BITS-1:0] pick_pixel(input t_px_style style);
        case (style)
            PX_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
            PX_NARROW:  return MF_PIXEL_BITS'(126 + $urandom_range(0, 4));
            PX_FLAT:    return '1;
            default:    return MF_PIXEL_BITS'($urandom);
        endcase
    endfunction

    // result side: random pop, or a long hold-off when the stimulus asks for one
    initial begin
        forever begin
            @(negedge i_clk);
            if (holds_done != holds_asked) begin
                pop <= 1'b0;
                repeat (STALL_CYCLES - 1) @(negedge i_clk);
                holds_done++;
            end else begin
                pop <= ($urandom_range(0, 99) >= rx_idle_pct());
            end
        end
    end

    // one pixel beat: optional idle cycles, then hold push until the block takes it
    task automatic drive_beat(input logic func, input logic [MF_PIXEL_BITS-1:0] pix);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct()) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push    <= 1'b1;
        i_func  <= func;
        i_pixel <= pix;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        beats_sent++;
    endtask

    // stop offering, wait for every due result, then let the pipeline run dry
    task automatic settle(input int extra_cycles);
        @(negedge i_clk);
        push <= 1'b0;
        wait (results_due == 0);
        repeat (extra_cycles) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_mf_reg idx, input int value);
        logic [MF_APB_BITS-1:0] word;
        // junk above the register bits must be dropped by the block
        word = $urandom;
        word[MF_CFG_BITS-1:0] = value[MF_CFG_BITS-1:0];
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {logic'(idx), 2'b00};
        pwdata  <= word;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // the checker compares prdata at the access edge
    task automatic read_reg(input t_mf_reg idx);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {logic'(idx), 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // one frame in raster order: h rows of pixels, one row of flush beats and one more
    // flush beat; noise puts flush beats inside the image and real pixels in flush rows;
    // a broken frame stops part way and needs a register write to restart
    task automatic run_frame(input bit reprogram, input int w_set, input int h_set,
                             input t_px_style style, input int noise_pct,
                             input bit broken, input bit with_stall);
        int                       w;
        int                       h;
        int                       total;
        int                       n;
        int                       cut_at;
        int                       pause_at;
        logic                     func;
        logic [MF_PIXEL_BITS-1:0] pix;
        if (reprogram) begin
            settle(SETTLE_CYCLES);
            cur_w_set = w_set;
            cur_h_set = h_set;
            write_reg(MF_REG_WIDTH, w_set);
            write_reg(MF_REG_HEIGHT, h_set);
            read_reg(MF_REG_WIDTH);
            read_reg(MF_REG_HEIGHT);
        end
        // zero acts as one, anything above the limit as the limit
        w = (cur_w_set % 4096 == 0) ? 1 : (cur_w_set % 4096 > MF_MAX_WIDTH) ? MF_MAX_WIDTH
                                                                         : cur_w_set % 4096;
        h = (cur_h_set % 4096 == 0) ? 1 : (cur_h_set % 4096 > MF_HEIGHT_LIMIT)
                                        ? MF_HEIGHT_LIMIT : cur_h_set % 4096;
        total    = (h + 1) * w + 1;
        cut_at   = broken ? $urandom_range(1, total - 1) : total;
        pause_at = ($urandom_range(0, 5) == 0) ? $urandom_range(1, total - 1) : -1;
        n = 0;
        while (n < cut_at) begin
            // sender waits here until the block has handed out everything due
            if (n == pause_at) begin
                settle(0);
            end
            if (n < h * w) begin
                func = ($urandom_range(0, 99) < noise_pct);
            end else begin
                func = !($urandom_range(0, 99) < noise_pct);
            end
            pix = (func || n >= h * w) ? MF_PIXEL_BITS'($urandom) : pick_pixel(style);
            drive_beat(func, pix);
            if (with_stall && n == 3) begin
                holds_asked++;
            end
            n++;
        end
        frame_cut = broken;
        if (!broken) begin
            frames_done++;
        end
    endtask

    initial begin
        #(RUN_LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int        base;
        int        sel;
        int        w;
        int        h;
        bit        reprogram;
        bit        stall_done;
        t_px_style style;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values of both registers
        read_reg(MF_REG_WIDTH);
        read_reg(MF_REG_HEIGHT);

        // small frames: 0 and 255 with flush beats in the image and pixels in flush rows
        run_frame(1'b1, 3, 3, PX_EXTREME, 30, 1'b0, 1'b0);
        // zero width and zero height act as one
        run_frame(1'b1, 0, 2, PX_RANDOM, 0, 1'b0, 1'b0);
        run_frame(1'b1, 2, 0, PX_EXTREME, 0, 1'b0, 1'b0);
        // frame abandoned part way, a register write restarts the position
        run_frame(1'b1, 2, 2, PX_RANDOM, 0, 1'b1, 1'b0);
        run_frame(1'b1, 2, 2, PX_NARROW, 20, 1'b0, 1'b0);

        // random frames, mostly small, mostly well formed
        base       = beats_sent;
        stall_done = 1'b0;
        while (beats_sent - base < RANDOM_BEATS) begin
            phase = (beats_sent - base < RANDOM_BEATS / 3) ? 0
                  : (beats_sent - base < 2 * RANDOM_BEATS / 3) ? 1 : 2;
            if (phase == 2 && !stall_done) begin
                // receiver holds off while the sender keeps offering, so full rises
                run_frame(1'b1, 16, 8, PX_RANDOM, 0, 1'b0, 1'b1);
                stall_done = 1'b1;
            end else begin
                sel = $urandom_range(0, 19);
                w = (sel < 14) ? $urandom_range(1, 8) : (sel < 19) ? $urandom_range(9, 24)
                                                                   : $urandom_range(25, 64);
                h = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 6)
                                                : $urandom_range(7, 16);
                // keep the setting now and then: frames run back to back
                reprogram = frame_cut || ($urandom_range(0, 2) != 0);
                style     = t_px_style'($urandom_range(0, 3));
                run_frame(reprogram, w, h, style,
                          ($urandom_range(0, 3) == 0) ? $urandom_range(5, 25) : 0,
                          ($urandom_range(0, 9) == 0), 1'b0);
            end
        end

        // largest register values are stored as written
        phase = 2;
        settle(SETTLE_CYCLES);
        write_reg(MF_REG_WIDTH, 4095);
        write_reg(MF_REG_HEIGHT, 4095);
        read_reg(MF_REG_WIDTH);
        read_reg(MF_REG_HEIGHT);

        settle(END_CYCLES);
        $display("covered %0d frames in %0d pixel beats, %0d filtered pixels compared",
                 frames_done, beats_sent, results_checked);
        $display("sizes 0 to 4095 written, register reads, broken frames and a long stall");
        if (mismatches == 0 && results_due == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
